// File: hdl/ppp_pkg.sv
// Package with the shared types and constants of the perspective point projector.
package ppp_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_COS_PITCH   = 3'd0;
    localparam logic [2:0] REG_SIN_PITCH   = 3'd1;
    localparam logic [2:0] REG_COS_YAW     = 3'd2;
    localparam logic [2:0] REG_SIN_YAW     = 3'd3;
    localparam logic [2:0] REG_HALF_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HALF_HEIGHT = 3'd5;
    localparam logic [2:0] REG_SCALE_X     = 3'd6;
    localparam logic [2:0] REG_SCALE_Y     = 3'd7;

    // Fixed widths of the register fields.
    localparam int TRIG_W  = 16;
    localparam int HALF_W  = 15;
    localparam int SCALE_W = 32;
    localparam int FRAC_W  = 16;

    // Register file as seen by the datapath.
    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_pitch;
        logic signed [TRIG_W-1:0] sin_pitch;
        logic signed [TRIG_W-1:0] cos_yaw;
        logic signed [TRIG_W-1:0] sin_yaw;
        logic [HALF_W-1:0]        half_width;
        logic [HALF_W-1:0]        half_height;
        logic [SCALE_W-1:0]       scale_x;
        logic [SCALE_W-1:0]       scale_y;
    } ppp_cfg_t;

endpackage

// File: hdl/ppp_rotate.sv
// Translation and yaw/pitch rotation stages of the projector.
module ppp_rotate import ppp_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [COORD_WIDTH-1:0] vx, vy, vz, ex, ey, ez,
    input  ppp_cfg_t                     cfg,
    output logic                         out_valid,
    output logic signed [COORD_WIDTH+4:0] dx,
    output logic signed [COORD_WIDTH+4:0] dy,
    output logic signed [COORD_WIDTH+4:0] dz
);
    // The subtraction adds one bit, and each rotation can add two more because a
    // Q2.14 factor reaches a magnitude of two.
    localparam int DW = COORD_WIDTH + 1;
    localparam int TW = COORD_WIDTH + 2;
    localparam int RW = COORD_WIDTH + 5;
    localparam int PW = COORD_WIDTH + 20;

    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DW-1:0] x1_reg, y1_reg, z1_reg;
    logic signed [PW-1:0] pt1_reg, pt2_reg, px1_reg, px2_reg;
    logic signed [DW-1:0] y2_reg;
    logic signed [RW-1:0] t3_reg, dx3_reg, y3_reg;
    logic signed [PW+2:0] py1_reg, py2_reg, pz1_reg, pz2_reg;
    logic signed [RW-1:0] dx4_reg;
    logic signed [PW+3:0] ysum, zsum;
    logic signed [PW:0]   tsum, xsum;

    // Stage 1: subtract the camera.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            x1_reg <= DW'(vx) - DW'(ex);
            y1_reg <= DW'(vy) - DW'(ey);
            z1_reg <= DW'(vz) - DW'(ez);
        end
    end

    // Stage 2: yaw products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            pt1_reg <= PW'(cfg.cos_yaw * z1_reg);
            pt2_reg <= PW'(cfg.sin_yaw * x1_reg);
            px1_reg <= PW'(cfg.cos_yaw * x1_reg);
            px2_reg <= PW'(cfg.sin_yaw * z1_reg);
            y2_reg  <= y1_reg;
        end
    end

    // Stage 3: yaw sums and floor by 2^14.
    assign tsum = (PW+1)'(pt1_reg) + (PW+1)'(pt2_reg);
    assign xsum = (PW+1)'(px1_reg) - (PW+1)'(px2_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            t3_reg  <= RW'(tsum >>> 14);
            dx3_reg <= RW'(xsum >>> 14);
            y3_reg  <= RW'(y2_reg);
        end
    end

    // Stage 4: pitch products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            py1_reg <= (PW+3)'(cfg.sin_pitch * t3_reg);
            py2_reg <= (PW+3)'(cfg.cos_pitch * y3_reg);
            pz1_reg <= (PW+3)'(cfg.cos_pitch * t3_reg);
            pz2_reg <= (PW+3)'(cfg.sin_pitch * y3_reg);
            dx4_reg <= dx3_reg;
        end
    end

    // Stage 5 is combinational here and registered by the next module.
    assign ysum = (PW+4)'(py1_reg) + (PW+4)'(py2_reg);
    assign zsum = (PW+4)'(pz1_reg) - (PW+4)'(pz2_reg);
    assign dy = RW'(ysum >>> 14);
    assign dz = RW'(zsum >>> 14);
    assign dx = dx4_reg;
    assign out_valid = v4_reg;
endmodule

// File: hdl/ppp_divide.sv
// Pipelined restoring divider with screen offset and saturation for one axis.
module ppp_divide import ppp_pkg::*; #(
    parameter int COORD_WIDTH  = 32,
    parameter int SCREEN_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic                          in_neg,   // sign of the result term
    input  logic [COORD_WIDTH+4:0]        num_mag,  // |d|
    input  logic [COORD_WIDTH+4:0]        den_mag,  // |dz|, nonzero when used
    input  logic [SCALE_W-1:0]            scale,
    input  logic [HALF_W-1:0]             half,
    output logic signed [SCREEN_WIDTH-1:0] coord,
    output logic                          clip
);
    // Quotient bits needed: integer result saturates beyond the screen range.
    localparam int MW = COORD_WIDTH + 5;
    localparam int NW = MW + SCALE_W;            // product width
    localparam int QB = SCREEN_WIDTH + FRAC_W + 1; // kept quotient bits
    localparam int SH = NW - QB;                 // upper product bits give "big"
    localparam int LIM = (1 << (SCREEN_WIDTH - 1)) - 1;
    localparam int VW = SCREEN_WIDTH + 3;

    // Stage A: product (cut into two partial products at bit 16 of the numerator).
    logic [NW-1:0] prod_lo_reg, prod_hi_reg;
    logic [MW-1:0] da_reg;
    logic          na_reg;
    logic [HALF_W-1:0] ha_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_lo_reg <= NW'(num_mag[15:0] * scale);
            prod_hi_reg <= NW'(num_mag[MW-1:16] * scale);
            da_reg      <= den_mag;
            na_reg      <= in_neg;
            ha_reg      <= half;
        end
    end

    // Division: one quotient bit per stage, remainder from the top bits.
    logic [MW:0]   rem_reg  [QB+1];
    logic [QB-1:0] quo_reg  [QB+1];
    logic [NW-1:0] low_reg  [QB+1];
    logic [MW-1:0] den_reg  [QB+1];
    logic          neg_reg  [QB+1];
    logic          big_reg  [QB+1];
    logic [HALF_W-1:0] hf_reg [QB+1];
    logic [NW-1:0] prod;

    // Stage B: combine, test for a quotient that cannot fit and load the first
    // divide stage. The top bits are below the divisor when not big, so they
    // start the remainder.
    assign prod = prod_lo_reg + (prod_hi_reg << 16);
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= (MW+1)'(prod >> QB);
            quo_reg[0] <= '0;
            low_reg[0] <= prod << (NW - QB);
            den_reg[0] <= da_reg;
            neg_reg[0] <= na_reg;
            // quotient >= 2^QB if high part of product >= divisor
            big_reg[0] <= (prod >> QB) >= NW'(da_reg);
            hf_reg[0]  <= ha_reg;
        end
    end

    for (genvar i = 0; i < QB; i++) begin : g_div
        logic [MW+1:0] trial;
        logic [MW+1:0] shifted;
        assign shifted = {rem_reg[i], low_reg[i][NW-1]};
        assign trial   = shifted - (MW+2)'(den_reg[i]);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!big_reg[i] && !trial[MW+1]) begin
                    rem_reg[i+1] <= trial[MW:0];
                    quo_reg[i+1] <= {quo_reg[i][QB-2:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= shifted[MW:0];
                    quo_reg[i+1] <= {quo_reg[i][QB-2:0], 1'b0};
                end
                low_reg[i+1] <= low_reg[i] << 1;
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                big_reg[i+1] <= big_reg[i];
                hf_reg[i+1]  <= hf_reg[i];
            end
        end
    end

    // Final stage: add or subtract the half size and saturate.
    logic [QB-FRAC_W-1:0] qint;
    logic                 inexact;
    logic signed [VW-1:0] q_s, h_s, v;
    assign qint    = quo_reg[QB][QB-1:FRAC_W];
    assign inexact = (rem_reg[QB] != '0) || (quo_reg[QB][FRAC_W-1:0] != '0);
    assign q_s     = VW'(qint);
    assign h_s     = VW'(hf_reg[QB]);
    always_comb begin
        if (!neg_reg[QB]) begin
            v = h_s + q_s;
        end else begin
            v = h_s - q_s;
            if (v > 0 && inexact) begin
                v = v - VW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (big_reg[QB]) begin
                coord <= neg_reg[QB] ? SCREEN_WIDTH'(-LIM - 1) : SCREEN_WIDTH'(LIM);
                clip  <= 1'b1;
            end else if (v > VW'(LIM)) begin
                coord <= SCREEN_WIDTH'(LIM);
                clip  <= 1'b1;
            end else if (v < -VW'(LIM) - VW'(1)) begin
                coord <= SCREEN_WIDTH'(-LIM - 1);
                clip  <= 1'b1;
            end else begin
                coord <= SCREEN_WIDTH'(v);
                clip  <= 1'b0;
            end
        end
    end
endmodule

// File: hdl/perspective_point_projector.sv
// Top level of the perspective point projector: registers, pipeline control, output.
// Pipeline: 4 rotation stages, 1 depth stage, 2 product stages, SCREEN_WIDTH+17 divide
// stages and 1 result stage, then the output register.
// Throughput: one vertex per clock; the whole pipeline advances when the output is free.
// Reset (aresetn low, synchronous) clears valid bits and loads register reset values.
module perspective_point_projector import ppp_pkg::*; #(
    parameter int COORD_WIDTH  = 32,
    parameter int SCREEN_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // vertex_x, vertex_y, vertex_z, eye_x, eye_y, eye_z from the lowest bit
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // screen_x, screen_y, zero_depth, clipped from the lowest bit
    output logic [((2*SCREEN_WIDTH+2+7)/8)*8-1:0] m_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [31:0]                 cfg_data
);
    localparam int CW = COORD_WIDTH;
    localparam int RW = CW + 5;
    localparam int DEPTH = SCREEN_WIDTH + FRAC_W + 1 + 3;
    localparam int OW = ((2*SCREEN_WIDTH+2+7)/8)*8;

    ppp_cfg_t cfg_reg;
    logic     en;

    // Configuration writes.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cos_pitch   <= 16'sd16384;
            cfg_reg.sin_pitch   <= '0;
            cfg_reg.cos_yaw     <= '0;
            cfg_reg.sin_yaw     <= 16'sd16384;
            cfg_reg.half_width  <= '0;
            cfg_reg.half_height <= '0;
            cfg_reg.scale_x     <= '0;
            cfg_reg.scale_y     <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_COS_PITCH:   cfg_reg.cos_pitch   <= cfg_data[TRIG_W-1:0];
                REG_SIN_PITCH:   cfg_reg.sin_pitch   <= cfg_data[TRIG_W-1:0];
                REG_COS_YAW:     cfg_reg.cos_yaw     <= cfg_data[TRIG_W-1:0];
                REG_SIN_YAW:     cfg_reg.sin_yaw     <= cfg_data[TRIG_W-1:0];
                REG_HALF_WIDTH:  cfg_reg.half_width  <= cfg_data[HALF_W-1:0];
                REG_HALF_HEIGHT: cfg_reg.half_height <= cfg_data[HALF_W-1:0];
                REG_SCALE_X:     cfg_reg.scale_x     <= cfg_data;
                REG_SCALE_Y:     cfg_reg.scale_y     <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is empty or being drained.
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    logic rv;
    logic signed [RW-1:0] dx, dy, dz;
    ppp_rotate #(.COORD_WIDTH(CW)) u_rot (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_tvalid),
        .vx(s_tdata[CW-1:0]), .vy(s_tdata[2*CW-1:CW]), .vz(s_tdata[3*CW-1:2*CW]),
        .ex(s_tdata[4*CW-1:3*CW]), .ey(s_tdata[5*CW-1:4*CW]),
        .ez(s_tdata[6*CW-1:5*CW]),
        .cfg(cfg_reg), .out_valid(rv), .dx(dx), .dy(dy), .dz(dz)
    );

    // Depth stage: magnitudes, signs and the zero depth test.
    logic [RW-1:0] mx_reg, my_reg, mz_reg;
    logic          nx_reg, ny_reg, zd_reg, v5_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= rv;
        end
        if (en) begin
            mx_reg <= dx[RW-1] ? RW'(-dx) : RW'(dx);
            my_reg <= dy[RW-1] ? RW'(-dy) : RW'(dy);
            mz_reg <= dz[RW-1] ? RW'(-dz) : RW'(dz);
            nx_reg <= dx[RW-1] ^ dz[RW-1];
            ny_reg <= !(dy[RW-1] ^ dz[RW-1]);
            zd_reg <= dz == '0;
        end
    end

    // Valid bit and zero depth flag delay line matching the divider.
    logic [DEPTH-1:0] vpipe_reg, zpipe_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vpipe_reg <= '0;
        end else if (en) begin
            vpipe_reg <= {vpipe_reg[DEPTH-2:0], v5_reg};
        end
        if (en) begin
            zpipe_reg <= {zpipe_reg[DEPTH-2:0], zd_reg};
        end
    end

    logic signed [SCREEN_WIDTH-1:0] sx, sy;
    logic                           cx, cy;
    ppp_divide #(.COORD_WIDTH(CW), .SCREEN_WIDTH(SCREEN_WIDTH)) u_div_x (
        .aclk(aclk), .en(en), .in_neg(nx_reg), .num_mag(mx_reg),
        .den_mag(zd_reg ? RW'(1) : mz_reg), .scale(cfg_reg.scale_x),
        .half(cfg_reg.half_width), .coord(sx), .clip(cx)
    );
    ppp_divide #(.COORD_WIDTH(CW), .SCREEN_WIDTH(SCREEN_WIDTH)) u_div_y (
        .aclk(aclk), .en(en), .in_neg(ny_reg), .num_mag(my_reg),
        .den_mag(zd_reg ? RW'(1) : mz_reg), .scale(cfg_reg.scale_y),
        .half(cfg_reg.half_height), .coord(sy), .clip(cy)
    );

    // Output register; a zero depth forces both coordinates to zero.
    logic zd_out;
    assign zd_out = zpipe_reg[DEPTH-1];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (en) begin
            m_tvalid <= vpipe_reg[DEPTH-1];
        end
        if (en) begin
            m_tdata <= OW'({(zd_out ? 1'b0 : (cx | cy)), zd_out,
                            (zd_out ? SCREEN_WIDTH'(0) : sy),
                            (zd_out ? SCREEN_WIDTH'(0) : sx)});
        end
    end

    // A stalled result holds its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    // Input is taken exactly when the output side can move.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow pipeline enable");
    // A zero depth result never reports clipping.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2*SCREEN_WIDTH] |-> !m_tdata[2*SCREEN_WIDTH+1])
        else $error("zero depth result flagged as clipped");
endmodule
